[src/ccsf_pkg.sv]
// Package: character codes and queue entry type for the C comment strip filter.
package ccsf_pkg;

	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_NONE    = 8'h00;

	// Bytes produced by one input transaction; cnt is 1 or 2 when queued.
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
	} ccsf_entry_t;

endpackage

[src/ccsf_front.sv]
// Front end: accepts input bytes, tracks comment/quote state, builds result entries.
module ccsf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	output logic                  push,
	output ccsf_pkg::ccsf_entry_t push_entry,
	input  logic                  push_ready
);
	import ccsf_pkg::*;

	logic       blk_q, skip_q, hslash_q, hstar_q, esc_q;
	logic [7:0] quote_q;

	logic       blk_d, skip_d, hslash_d, hstar_d, esc_d;
	logic [7:0] quote_d;
	logic [1:0] cnt;
	logic [7:0] b0, b1;
	logic       done;
	logic       accept;

	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;

	always_comb begin
		blk_d   = blk_q;
		skip_d  = skip_q;
		hslash_d = hslash_q;
		hstar_d = hstar_q;
		esc_d   = esc_q;
		quote_d = quote_q;
		cnt     = 2'd0;
		b0      = CH_NONE;
		b1      = CH_NONE;
		done    = 1'b0;

		if (esc_q) begin
			esc_d = 1'b0;
			b0    = in_byte;
			cnt   = 2'd1;
			done  = 1'b1;
		end else if (skip_q) begin
			if (in_byte == CH_NEWLINE) begin
				skip_d = 1'b0;
			end
			done = 1'b1;
		end

		if (!done && hslash_q) begin
			hslash_d = 1'b0;
			if (in_byte == CH_SLASH) begin
				b0     = CH_NEWLINE;
				cnt    = 2'd1;
				skip_d = 1'b1;
				done   = 1'b1;
			end else if (in_byte == CH_STAR) begin
				blk_d = 1'b1;
				done  = 1'b1;
			end else if (!blk_q) begin
				b0  = CH_SLASH;
				cnt = 2'd1;
			end
		end

		if (!done && hstar_q) begin
			hstar_d = 1'b0;
			if (in_byte == CH_SLASH) begin
				blk_d = 1'b0;
				done  = 1'b1;
			end
		end

		if (!done) begin
			logic emit_b;
			emit_b = 1'b0;
			case (in_byte)
				CH_BSLASH: begin
					if (!blk_d) begin
						emit_b = 1'b1;
						esc_d  = 1'b1;
					end
				end
				CH_DQUOTE, CH_SQUOTE: begin
					if (!blk_d) begin
						emit_b = 1'b1;
						if (quote_q == CH_NONE) begin
							quote_d = in_byte;
						end else if (quote_q == in_byte) begin
							quote_d = CH_NONE;
						end
					end
				end
				CH_SLASH: begin
					if (quote_q != CH_NONE) begin
						emit_b = 1'b1;
					end else begin
						hslash_d = 1'b1;
					end
				end
				CH_STAR: begin
					if (quote_q != CH_NONE) begin
						emit_b = 1'b1;
					end else if (blk_d) begin
						hstar_d = 1'b1;
					end else begin
						emit_b = 1'b1;
					end
				end
				default: begin
					if (!blk_d) begin
						emit_b = 1'b1;
					end
				end
			endcase
			if (emit_b) begin
				if (cnt == 2'd0) begin
					b0  = in_byte;
					cnt = 2'd1;
				end else begin
					b1  = in_byte;
					cnt = 2'd2;
				end
			end
		end

		if (in_last) begin
			if (hslash_d && !blk_d && cnt != 2'd2) begin
				if (cnt == 2'd0) begin
					b0  = CH_SLASH;
					cnt = 2'd1;
				end else begin
					b1  = CH_SLASH;
					cnt = 2'd2;
				end
			end
			blk_d    = 1'b0;
			skip_d   = 1'b0;
			hslash_d = 1'b0;
			hstar_d  = 1'b0;
			esc_d    = 1'b0;
			quote_d  = CH_NONE;
		end
	end

	assign push           = accept && (cnt != 2'd0);
	assign push_entry.cnt = cnt;
	assign push_entry.b0  = b0;
	assign push_entry.b1  = b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q    <= 1'b0;
			skip_q   <= 1'b0;
			hslash_q <= 1'b0;
			hstar_q  <= 1'b0;
			esc_q    <= 1'b0;
			quote_q  <= CH_NONE;
		end else if (accept) begin
			blk_q    <= blk_d;
			skip_q   <= skip_d;
			hslash_q <= hslash_d;
			hstar_q  <= hstar_d;
			esc_q    <= esc_d;
			quote_q  <= quote_d;
		end
	end

endmodule

[src/ccsf_queue.sv]
// Small register queue of result entries between front and back end.
module ccsf_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ccsf_pkg::ccsf_entry_t push_entry,
	output logic                  push_ready,
	output logic                  head_valid,
	output ccsf_pkg::ccsf_entry_t head_entry,
	input  logic                  pop
);
	import ccsf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	ccsf_entry_t        mem_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]      count_q;
	logic               do_push, do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/ccsf_back.sv]
// Back end: serializes queued entries into the registered output stream.
module ccsf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  ccsf_pkg::ccsf_entry_t head_entry,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  out_last
);
	import ccsf_pkg::*;

	logic       out_valid_q, out_last_q, sel_q;
	logic [7:0] out_byte_q;
	logic       load, is_last;

	assign load    = head_valid && (!out_valid_q || out_ready);
	assign is_last = sel_q || (head_entry.cnt == 2'd1);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sel_q       <= !is_last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= sel_q ? head_entry.b1 : head_entry.b0;
			out_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

[src/c_comment_strip_filter_top.sv]
// Top level of the C comment strip filter: front end, entry queue, back end.
// Input: one byte per cycle; in_ready drops only when the entry queue is full.
// Path: input bytes kept are queued as entries, then loaded into the output register.
// Output: one byte per cycle while out_ready is high; a two-byte entry goes out b0, then b1.
// Reset: arst_n clears all comment/quote state, the queue and the output valid flag.
module c_comment_strip_filter_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import ccsf_pkg::*;

	logic        push, push_ready, head_valid, pop;
	ccsf_entry_t push_entry, head_entry;

	ccsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	ccsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	ccsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

endmodule

[bench/c_comment_strip_filter_checker.sv]
// Checker: predicts the stripped byte stream and compares it with the output channel.
`timescale 1ns / 1ps

module c_comment_strip_filter_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       out_last,
	output int         fail_count,
	output int         waiting
);
	import ccsf_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} stripped_t;

	stripped_t  stripped_q[$];

	logic       in_block;
	logic       skipping;
	logic [7:0] quote_ch;
	logic       slash_held;
	logic       star_held;
	logic       esc_pend;

	logic [7:0] step_buf[2];
	int         step_n;

	initial begin
		fail_count = 0;
		waiting = 0;
	end

	function automatic void emit_char(input logic [7:0] c);
		if (step_n < 2) begin
			step_buf[step_n] = c;
			step_n++;
		end
	endfunction

	task automatic clear_state();
		in_block = 1'b0;
		skipping = 1'b0;
		quote_ch = CH_NONE;
		slash_held = 1'b0;
		star_held = 1'b0;
		esc_pend = 1'b0;
	endtask

	task automatic strip_char(input logic [7:0] c);
		if (esc_pend) begin
			esc_pend = 1'b0;
			emit_char(c);
			return;
		end
		if (skipping) begin
			if (c == CH_NEWLINE)
				skipping = 1'b0;
			return;
		end
		if (slash_held) begin
			slash_held = 1'b0;
			if (c == CH_SLASH) begin
				emit_char(CH_NEWLINE);
				skipping = 1'b1;
				return;
			end
			if (c == CH_STAR) begin
				in_block = 1'b1;
				return;
			end
			if (!in_block)
				emit_char(CH_SLASH);
		end
		if (star_held) begin
			star_held = 1'b0;
			if (c == CH_SLASH) begin
				in_block = 1'b0;
				return;
			end
		end
		case (c)
			CH_BSLASH: if (!in_block) begin
				emit_char(c);
				esc_pend = 1'b1;
			end
			CH_DQUOTE, CH_SQUOTE: if (!in_block) begin
				emit_char(c);
				if (quote_ch == CH_NONE)
					quote_ch = c;
				else if (quote_ch == c)
					quote_ch = CH_NONE;
			end
			CH_SLASH: begin
				if (quote_ch != CH_NONE)
					emit_char(c);
				else
					slash_held = 1'b1;
			end
			CH_STAR: begin
				if (quote_ch != CH_NONE || !in_block)
					emit_char(c);
				else
					star_held = 1'b1;
			end
			default: if (!in_block)
				emit_char(c);
		endcase
	endtask

	task automatic strip_step(input logic [7:0] c, input logic fin);
		step_n = 0;
		strip_char(c);
		if (fin) begin
			if (slash_held && !in_block)
				emit_char(CH_SLASH);
			clear_state();
		end
		for (int i = 0; i < step_n; i++)
			stripped_q.push_back('{ch: step_buf[i], fin: (i == step_n - 1)});
	endtask

	always @(posedge clk or negedge arst_n) begin
		stripped_t exp_out;
		if (!arst_n) begin
			clear_state();
			stripped_q.delete();
			waiting <= 0;
		end else begin
			if (in_valid && in_ready)
				strip_step(in_byte, in_last);
			if (out_valid && out_ready) begin
				if (stripped_q.size() == 0) begin
					$display("%0t: unexpected transaction byte=%h last=%b",
						$time, out_byte, out_last);
					fail_count++;
				end else begin
					exp_out = stripped_q.pop_front();
					if (exp_out.ch !== out_byte || exp_out.fin !== out_last) begin
						$display("%0t: mismatch expected byte=%h last=%b actual byte=%h last=%b",
							$time, exp_out.ch, exp_out.fin, out_byte, out_last);
						fail_count++;
					end
				end
			end
			waiting <= stripped_q.size();
		end
	end

endmodule

[bench/testbench.sv]
// Testbench top: clock, reset, text stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;
	import ccsf_pkg::*;

	localparam int RANDOM_ITEMS = 1650;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       out_last;

	int         fail_count;
	int         waiting;

	logic [7:0] text_q[$];
	int         sent;
	int         burst_left;
	int         rx_cyc;
	int         rx_mode;

	c_comment_strip_filter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.out_last (out_last)
	);

	c_comment_strip_filter_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.fail_count(fail_count),
		.waiting   (waiting)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#800000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic [7:0] letter_char();
		return 8'h61 + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] text_char();
		case ($urandom_range(0, 11))
			0, 1, 2, 3: return letter_char();
			4:          return 8'h20;
			5:          return CH_NEWLINE;
			6:          return CH_SLASH;
			7:          return CH_STAR;
			8:          return CH_DQUOTE;
			9:          return CH_SQUOTE;
			10:         return CH_BSLASH;
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				in_valid = 1'b0;
				in_byte = 8'($urandom);
				in_last = 1'($urandom);
			end
			burst_left = $urandom_range(1, 40);
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_byte = c;
		in_last = fin;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		sent++;
	endtask

	task automatic send_text(input logic fin);
		for (int i = 0; i < text_q.size(); i++)
			send_char(text_q[i], fin && (i == text_q.size() - 1));
		text_q.delete();
	endtask

	task automatic build_stream();
		logic [7:0] q;
		repeat ($urandom_range(3, 15)) begin
			case ($urandom_range(0, 9))
				0, 1: repeat ($urandom_range(1, 6)) text_q.push_back(letter_char());
				2: text_q.push_back($urandom_range(0, 1) ? CH_NEWLINE : 8'h20);
				3: begin
					push_text("//");
					repeat ($urandom_range(0, 8)) text_q.push_back(text_char());
					text_q.push_back(CH_NEWLINE);
				end
				4: begin
					push_text("/*");
					repeat ($urandom_range(0, 10)) text_q.push_back(text_char());
					push_text("*/");
				end
				5: begin
					q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
					text_q.push_back(q);
					repeat ($urandom_range(0, 6)) begin
						if ($urandom_range(0, 4) == 0)
							text_q.push_back(CH_BSLASH);
						text_q.push_back(text_char());
					end
					text_q.push_back(q);
				end
				6: begin
					text_q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
					text_q.push_back(letter_char());
				end
				7: begin
					text_q.push_back(CH_BSLASH);
					text_q.push_back(text_char());
				end
				8: repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
				default: repeat ($urandom_range(1, 5)) text_q.push_back(text_char());
			endcase
		end
		// broken stream: cut short at a random point
		if ($urandom_range(0, 3) == 0)
			while (text_q.size() > 1 && $urandom_range(0, 2) != 0)
				void'(text_q.pop_back());
	endtask

	// receiver back-pressure
	initial begin
		out_ready = 1'b0;
		rx_cyc = 0;
		rx_mode = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cyc++;
			if (rx_cyc == 1500 || rx_cyc == 3500) begin
				out_ready = 1'b0;
				repeat (100) @(negedge clk);
				rx_cyc += 100;
			end else begin
				if (rx_cyc % 200 == 0)
					rx_mode = $urandom_range(0, 3);
				case (rx_mode)
					0: out_ready = 1'b1;
					1: out_ready = 1'($urandom_range(0, 1));
					2: out_ready = ($urandom_range(0, 4) == 0);
					default: out_ready = (rx_cyc % 3 != 0);
				endcase
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		in_last = 1'b0;
		sent = 0;
		burst_left = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		text_q.push_back(8'hFF);
		text_q.push_back(8'h00);
		push_text("//x\n/*/\\\"*x*//*//\n*/\\/\"'\"/k");
		send_text(1'b0);
		push_text("/");
		send_text(1'b1);

		while (sent < RANDOM_ITEMS + 30) begin
			build_stream();
			send_text($urandom_range(0, 1));
		end
		@(negedge clk);
		in_valid = 1'b0;

		while (waiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[sim.f]
src/ccsf_pkg.sv
src/ccsf_front.sv
src/ccsf_queue.sv
src/ccsf_back.sv
src/c_comment_strip_filter_top.sv
bench/c_comment_strip_filter_checker.sv
bench/testbench.sv
